[hdl/pbc_pkg.sv]
// Package for the partitioned block convolver.
// Holds shared constants, the sequencer state type and the per-tap control struct.
// No dependencies.
package pbc_pkg;

  localparam int BLOCK_SIZE_DEF = 64;
  localparam int MAX_BLOCKS_DEF = 16;

  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = 10;
  localparam int KL_W     = 11;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF   = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_RUN,
    ST_DRAIN
  } pbc_state_e;

  // Control that travels alongside one multiply-accumulate step.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic zero;
  } pbc_tap_t;

endpackage

[hdl/partitioned_block_convolver.sv]
// Partitioned block convolver: each output passes through a start state, one
// MAC step per tap in the run state, then the store read, product and
// accumulator registers of the MAC pipeline; the first output of a block follows
// the beat that completes the block. Throughput is set by the single shared MAC.
// After reset the coefficient store is cleared entry by entry, during which
// input beats are stalled; kernel_length resets to one.
module partitioned_block_convolver #(
  parameter int BLOCK_SIZE = pbc_pkg::BLOCK_SIZE_DEF,
  parameter int MAX_BLOCKS = pbc_pkg::MAX_BLOCKS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pbc_pkg::KL_W-1:0]            cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                req_type_i,
  input  logic signed [pbc_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic [pbc_pkg::IDX_W-1:0]           coef_index_i,
  input  logic signed [pbc_pkg::SAMPLE_W-1:0] coef_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pbc_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic                                last_of_block_o,
  output logic                                saturated_o
);

  localparam int KMAX = BLOCK_SIZE * MAX_BLOCKS;
  localparam int HD   = KMAX + BLOCK_SIZE;
  localparam int KW   = $clog2(KMAX);
  localparam int HAW  = $clog2(HD);

  logic [pbc_pkg::KL_W-1:0] kernel_length_q;

  logic                                rd_en;
  logic                                coef_we;
  logic [KW-1:0]                       coef_addr;
  logic signed [pbc_pkg::SAMPLE_W-1:0] coef_wdata;
  logic                                hist_we;
  logic [HAW-1:0]                      hist_addr;
  logic signed [pbc_pkg::SAMPLE_W-1:0] coef_rdata;
  logic signed [pbc_pkg::SAMPLE_W-1:0] hist_rdata;
  pbc_pkg::pbc_tap_t                   tap;
  logic                                j_last;
  logic                                mac_done;
  logic signed [pbc_pkg::SAMPLE_W-1:0] mac_result;
  logic                                mac_sat;
  logic                                out_free;

  logic                                out_valid_q, out_valid_d;
  logic signed [pbc_pkg::SAMPLE_W-1:0] out_data_q;
  logic                                out_last_q;
  logic                                out_sat_q;

  // The tap count register; write it only while the block is idle (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_length_q <= pbc_pkg::KL_W'(1);
    end else if (cfg_we_i) begin
      kernel_length_q <= cfg_wdata_i;
    end
  end

  // The output register is free when empty or when its beat is taken now. The
  // sequencer only starts an output once this holds, so a finished result never
  // finds the register occupied.
  assign out_free = !out_valid_q || !out_stall_i;

  pbc_sequencer #(
    .BLOCK_SIZE (BLOCK_SIZE),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .coef_index_i    (coef_index_i),
    .coef_value_i    (coef_value_i),
    .kernel_length_i (kernel_length_q),
    .out_free_i      (out_free),
    .mac_done_i      (mac_done),
    .rd_en_o         (rd_en),
    .coef_we_o       (coef_we),
    .coef_addr_o     (coef_addr),
    .coef_wdata_o    (coef_wdata),
    .hist_we_o       (hist_we),
    .hist_addr_o     (hist_addr),
    .tap_o           (tap),
    .j_last_o        (j_last)
  );

  pbc_store #(
    .BLOCK_SIZE (BLOCK_SIZE),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_store (
    .clk_i        (clk_i),
    .rd_en_i      (rd_en),
    .coef_we_i    (coef_we),
    .coef_addr_i  (coef_addr),
    .coef_wdata_i (coef_wdata),
    .hist_we_i    (hist_we),
    .hist_addr_i  (hist_addr),
    .hist_wdata_i (sample_in_i),
    .coef_rdata_o (coef_rdata),
    .hist_rdata_o (hist_rdata)
  );

  pbc_mac #(
    .BLOCK_SIZE (BLOCK_SIZE),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tap_i    (tap),
    .coef_i   (coef_rdata),
    .sample_i (hist_rdata),
    .done_o   (mac_done),
    .result_o (mac_result),
    .sat_o    (mac_sat)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (mac_done) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // The sequencer still holds the output index while the result lands.
  always_ff @(posedge clk_i) begin
    if (mac_done) begin
      out_data_q <= mac_result;
      out_last_q <= j_last;
      out_sat_q  <= mac_sat;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sample_out_o    = out_data_q;
  assign last_of_block_o = out_last_q;
  assign saturated_o     = out_sat_q;

endmodule

[hdl/pbc_store.sv]
// Coefficient and sample history memories of the partitioned block convolver.
// Single port each, registered read data. Depends on pbc_pkg.
module pbc_store #(
  parameter int BLOCK_SIZE = pbc_pkg::BLOCK_SIZE_DEF,
  parameter int MAX_BLOCKS = pbc_pkg::MAX_BLOCKS_DEF,
  localparam int KMAX = BLOCK_SIZE * MAX_BLOCKS,
  localparam int HD   = KMAX + BLOCK_SIZE,
  localparam int KW   = $clog2(KMAX),
  localparam int HAW  = $clog2(HD)
) (
  input  logic                                clk_i,
  input  logic                                rd_en_i,
  input  logic                                coef_we_i,
  input  logic [KW-1:0]                       coef_addr_i,
  input  logic signed [pbc_pkg::SAMPLE_W-1:0] coef_wdata_i,
  input  logic                                hist_we_i,
  input  logic [HAW-1:0]                      hist_addr_i,
  input  logic signed [pbc_pkg::SAMPLE_W-1:0] hist_wdata_i,
  output logic signed [pbc_pkg::SAMPLE_W-1:0] coef_rdata_o,
  output logic signed [pbc_pkg::SAMPLE_W-1:0] hist_rdata_o
);

  logic signed [pbc_pkg::SAMPLE_W-1:0] coef_mem [KMAX];
  logic signed [pbc_pkg::SAMPLE_W-1:0] hist_mem [HD];
  logic signed [pbc_pkg::SAMPLE_W-1:0] coef_rdata_q;
  logic signed [pbc_pkg::SAMPLE_W-1:0] hist_rdata_q;

  always_ff @(posedge clk_i) begin
    if (coef_we_i) begin
      coef_mem[coef_addr_i] <= coef_wdata_i;
    end
    if (rd_en_i) begin
      coef_rdata_q <= coef_mem[coef_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we_i) begin
      hist_mem[hist_addr_i] <= hist_wdata_i;
    end
    if (rd_en_i) begin
      hist_rdata_q <= hist_mem[hist_addr_i];
    end
  end

  assign coef_rdata_o = coef_rdata_q;
  assign hist_rdata_o = hist_rdata_q;

endmodule

[hdl/pbc_mac.sv]
// Shared multiply-accumulate unit with rounding and saturation to Q1.15.
// Depends on pbc_pkg for the tap control struct.
module pbc_mac #(
  parameter int BLOCK_SIZE = pbc_pkg::BLOCK_SIZE_DEF,
  parameter int MAX_BLOCKS = pbc_pkg::MAX_BLOCKS_DEF,
  localparam int KMAX = BLOCK_SIZE * MAX_BLOCKS,
  localparam int AW   = 2 * pbc_pkg::SAMPLE_W + $clog2(KMAX) + 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pbc_pkg::pbc_tap_t                   tap_i,
  input  logic signed [pbc_pkg::SAMPLE_W-1:0] coef_i,
  input  logic signed [pbc_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                done_o,
  output logic signed [pbc_pkg::SAMPLE_W-1:0] result_o,
  output logic                                sat_o
);

  localparam int PW = 2 * pbc_pkg::SAMPLE_W;
  localparam logic signed [AW-1:0] RND  = AW'(16384);
  localparam logic signed [AW-1:0] QMAX = AW'(32767);
  localparam logic signed [AW-1:0] QMIN = AW'(-32768);

  pbc_pkg::pbc_tap_t    tap1_q;
  pbc_pkg::pbc_tap_t    tap2_q;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_q, prod_d;
  logic signed [AW-1:0] acc_q, acc_d;
  logic                 done_q;
  logic signed [AW-1:0] quot;

  assign prod = coef_i * sample_i;

  // The tap control is delayed once to meet the registered store read data and
  // once more alongside the product. Taps reaching before the stream start
  // contribute nothing, whatever the history holds there.
  always_comb begin
    prod_d = tap1_q.zero ? '0 : prod;
    acc_d  = acc_q;
    if (tap2_q.valid) begin
      if (tap2_q.first) begin
        acc_d = AW'(prod_q);
      end else begin
        acc_d = acc_q + AW'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap1_q <= '0;
      tap2_q <= '0;
      done_q <= 1'b0;
    end else begin
      tap1_q <= tap_i;
      tap2_q <= tap1_q;
      done_q <= tap2_q.valid && tap2_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  // Halves go upwards: add half a Q1.15 step, then floor with an arithmetic shift.
  always_comb begin
    quot = (acc_q + RND) >>> 15;
    if (quot > QMAX) begin
      result_o = QMAX[pbc_pkg::SAMPLE_W-1:0];
      sat_o    = 1'b1;
    end else if (quot < QMIN) begin
      result_o = QMIN[pbc_pkg::SAMPLE_W-1:0];
      sat_o    = 1'b1;
    end else begin
      result_o = quot[pbc_pkg::SAMPLE_W-1:0];
      sat_o    = 1'b0;
    end
  end

  assign done_o = done_q;

endmodule

[hdl/pbc_sequencer.sv]
// Sequencer of the partitioned block convolver: clearing pass, input handling,
// history pointers and the tap loop. Depends on pbc_pkg.
module pbc_sequencer #(
  parameter int BLOCK_SIZE = pbc_pkg::BLOCK_SIZE_DEF,
  parameter int MAX_BLOCKS = pbc_pkg::MAX_BLOCKS_DEF,
  localparam int KMAX = BLOCK_SIZE * MAX_BLOCKS,
  localparam int HD   = KMAX + BLOCK_SIZE,
  localparam int KW   = $clog2(KMAX),
  localparam int HAW  = $clog2(HD)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                req_type_i,
  input  logic [pbc_pkg::IDX_W-1:0]           coef_index_i,
  input  logic signed [pbc_pkg::SAMPLE_W-1:0] coef_value_i,
  input  logic [pbc_pkg::KL_W-1:0]            kernel_length_i,
  input  logic                                out_free_i,
  input  logic                                mac_done_i,
  output logic                                rd_en_o,
  output logic                                coef_we_o,
  output logic [KW-1:0]                       coef_addr_o,
  output logic signed [pbc_pkg::SAMPLE_W-1:0] coef_wdata_o,
  output logic                                hist_we_o,
  output logic [HAW-1:0]                      hist_addr_o,
  output pbc_pkg::pbc_tap_t                   tap_o,
  output logic                                j_last_o
);

  localparam int CNTW = $clog2(HD + 1);
  localparam int PW   = $clog2(BLOCK_SIZE);
  localparam int HAW1 = HAW + 1;

  pbc_pkg::pbc_state_e state_q, state_d;
  logic [KW-1:0]   clr_q, clr_d;
  logic [HAW-1:0]  wp_q, wp_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [PW-1:0]   pos_q, pos_d;
  logic [PW-1:0]   j_q, j_d;
  logic [HAW-1:0]  base_q, base_d;
  logic [HAW-1:0]  nb_q, nb_d;
  logic [KW-1:0]   k_q, k_d;
  logic [HAW-1:0]  rp_q, rp_d;
  logic [HAW-1:0]  n_q, n_d;
  logic [KW-1:0]   tm1_q, tm1_d;
  logic [KW-1:0]   taps_m1;
  logic [HAW-1:0]  wp_inc;
  logic [CNTW-1:0] cnt_inc;
  logic [HAW1-1:0] bsum;
  logic [HAW1-1:0] rsum;

  // Taps in use, less one: zero counts as one tap, anything past the store as all.
  always_comb begin
    if (kernel_length_i == '0) begin
      taps_m1 = '0;
    end else if (32'(kernel_length_i) > 32'(KMAX)) begin
      taps_m1 = KW'(KMAX - 1);
    end else begin
      taps_m1 = KW'(kernel_length_i - pbc_pkg::KL_W'(1));
    end
  end

  always_comb begin
    wp_inc  = (wp_q == HAW'(HD - 1)) ? '0 : wp_q + 1'b1;
    cnt_inc = (cnt_q == CNTW'(HD)) ? cnt_q : cnt_q + 1'b1;
    if (wp_inc >= HAW'(BLOCK_SIZE)) begin
      bsum = HAW1'(wp_inc) - HAW1'(BLOCK_SIZE);
    end else begin
      bsum = HAW1'(wp_inc) + HAW1'(HD - BLOCK_SIZE);
    end
    rsum = HAW1'(base_q) + HAW1'(j_q);
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    wp_d         = wp_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    j_d          = j_q;
    base_d       = base_q;
    nb_d         = nb_q;
    k_d          = k_q;
    rp_d         = rp_q;
    n_d          = n_q;
    tm1_d        = tm1_q;
    in_stall_o   = 1'b1;
    rd_en_o      = 1'b0;
    coef_we_o    = 1'b0;
    coef_addr_o  = k_q;
    coef_wdata_o = coef_value_i;
    hist_we_o    = 1'b0;
    hist_addr_o  = wp_q;
    tap_o        = '0;

    unique case (state_q)
      pbc_pkg::ST_CLEAR: begin
        coef_we_o    = 1'b1;
        coef_addr_o  = clr_q;
        coef_wdata_o = '0;
        clr_d        = clr_q + 1'b1;
        if (clr_q == KW'(KMAX - 1)) begin
          state_d = pbc_pkg::ST_IDLE;
        end
      end
      pbc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (req_type_i == pbc_pkg::REQ_COEF) begin
            coef_addr_o = KW'(coef_index_i);
            coef_we_o   = 32'(coef_index_i) < 32'(KMAX);
            wp_d        = '0;
            cnt_d       = '0;
            pos_d       = '0;
          end else begin
            hist_we_o = 1'b1;
            wp_d      = wp_inc;
            cnt_d     = cnt_inc;
            if (pos_q == PW'(BLOCK_SIZE - 1)) begin
              pos_d   = '0;
              base_d  = HAW'(bsum);
              nb_d    = HAW'(cnt_inc - CNTW'(BLOCK_SIZE));
              j_d     = '0;
              tm1_d   = taps_m1;
              state_d = pbc_pkg::ST_START;
            end else begin
              pos_d = pos_q + 1'b1;
            end
          end
        end
      end
      pbc_pkg::ST_START: begin
        if (out_free_i) begin
          k_d     = '0;
          rp_d    = (rsum >= HAW1'(HD)) ? HAW'(rsum - HAW1'(HD)) : HAW'(rsum);
          n_d     = nb_q + HAW'(j_q);
          state_d = pbc_pkg::ST_RUN;
        end
      end
      pbc_pkg::ST_RUN: begin
        rd_en_o     = 1'b1;
        coef_addr_o = k_q;
        hist_addr_o = rp_q;
        tap_o.valid = 1'b1;
        tap_o.first = (k_q == '0);
        tap_o.last  = (k_q == tm1_q);
        tap_o.zero  = HAW'(k_q) > n_q;
        k_d         = k_q + 1'b1;
        rp_d        = (rp_q == '0) ? HAW'(HD - 1) : rp_q - 1'b1;
        if (k_q == tm1_q) begin
          state_d = pbc_pkg::ST_DRAIN;
        end
      end
      pbc_pkg::ST_DRAIN: begin
        if (mac_done_i) begin
          if (j_q == PW'(BLOCK_SIZE - 1)) begin
            state_d = pbc_pkg::ST_IDLE;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = pbc_pkg::ST_START;
          end
        end
      end
      default: begin
        state_d = pbc_pkg::ST_IDLE;
      end
    endcase
  end

  assign j_last_o = (j_q == PW'(BLOCK_SIZE - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pbc_pkg::ST_CLEAR;
      clr_q   <= '0;
      wp_q    <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      wp_q    <= wp_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    nb_q   <= nb_d;
    k_q    <= k_d;
    rp_q   <= rp_d;
    n_q    <= n_d;
    tm1_q  <= tm1_d;
  end

endmodule

[hdl/pbc_checker.sv]
// Port-level checks for the partitioned block convolver, bound to the top level.
// Depends on pbc_pkg for field widths.
module pbc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [pbc_pkg::SAMPLE_W-1:0] sample_out_o,
  input logic                                last_of_block_o,
  input logic                                saturated_o
);

  // A stalled output beat stays offered.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat withdrawn while stalled");

  // A stalled output beat keeps its payload.
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(sample_out_o) && $stable(last_of_block_o) && $stable(saturated_o))
    else $error("output payload changed while stalled");

  // Mid-block, the block is still busy and takes no input.
  a_busy_mid_block : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_block_o |=> in_stall_o)
    else $error("input accepted in the middle of a block's outputs");

  // A clipped result sits on one of the Q1.15 bounds.
  a_sat_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      (sample_out_o == 16'sh7fff) || (sample_out_o == 16'sh8000))
    else $error("saturated result not at a bound");

endmodule

bind partitioned_block_convolver pbc_checker u_pbc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .sample_out_o    (sample_out_o),
  .last_of_block_o (last_of_block_o),
  .saturated_o     (saturated_o)
);
